[rtl/fir_decimate_by_two_assert.svh]
// Assertion helpers for the top RTL file; clocked on clk_i, off during reset.
`ifndef FIR_DECIMATE_BY_TWO_ASSERT_SVH
`define FIR_DECIMATE_BY_TWO_ASSERT_SVH

// Same-cycle implication
`define FDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fdb_pkg.sv]
package fdb_pkg;

  // Filter geometry
  localparam int TAPS       = 32;
  localparam int COEF_COUNT = 32;
  localparam int SHIFT      = 15;
  localparam int SMP_W      = 16;
  localparam int PROD_W     = 2 * SMP_W;
  localparam int IDX_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int ACC_W      = PROD_W + IDX_W;
  localparam int Y_W        = ACC_W - SHIFT;

  // Q15 coefficients, oldest sample first
  localparam logic signed [SMP_W-1:0] COEF_ROM [COEF_COUNT] = '{
    16'sh008d,  16'sh019c,  16'sh01cb, -16'sh0011, -16'sh0254, -16'sh01b4,  16'sh01be,
    16'sh0342, -16'sh002e, -16'sh0426, -16'sh022b,  16'sh03e2,  16'sh04d4, -16'sh0211,
    -16'sh0710, -16'sh0178,  16'sh07c9,  16'sh065e, -16'sh05bb, -16'sh0b75, -16'sh005f,
    16'sh0e25,  16'sh0ae8, -16'sh09a1, -16'sh16fa, -16'sh099a,  16'sh15e9,  16'sh2d66,
    16'sh2d4e,  16'sh1c73,  16'sh0b1e,  16'sh022a
  };

  // Sequencer command to the MAC
  typedef struct packed {
    logic             valid;
    logic             first;
    logic [IDX_W-1:0] idx;
  } mac_ctrl_t;

  // Finished output sample
  typedef struct packed {
    logic signed [SMP_W-1:0] filtered;
    logic                    overflow;
  } res_t;

  // Coefficient for tap idx; taps past the table weigh zero
  function automatic logic signed [SMP_W-1:0] coef_at(input logic [IDX_W-1:0] idx);
    int unsigned i;
    i = int'(idx);
    if (i < COEF_COUNT) begin
      return COEF_ROM[i];
    end
    return '0;
  endfunction

endpackage

[rtl/fdb_smp_if.sv]
interface fdb_smp_if;
  import fdb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[rtl/fdb_res_if.sv]
interface fdb_res_if;
  import fdb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] filtered;
  logic                    overflow;

  modport source (output valid, output filtered, output overflow, input ready);
  modport sink   (input valid, input filtered, input overflow, output ready);
endinterface

[rtl/fdb_cell.sv]
module fdb_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic signed [fdb_pkg::SMP_W-1:0] d_i,
  output logic signed [fdb_pkg::SMP_W-1:0] q_o
);
  import fdb_pkg::*;

  logic signed [SMP_W-1:0] smp_q;

  // Take the neighbor's sample whenever the row moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
    end else if (en_i) begin
      smp_q <= d_i;
    end
  end

  assign q_o = smp_q;
endmodule

[rtl/fdb_mac.sv]
module fdb_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fdb_pkg::mac_ctrl_t              ctrl_i,
  input  logic signed [fdb_pkg::SMP_W-1:0] sample_i,
  output fdb_pkg::res_t                   res_o
);
  import fdb_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic                     prod_first_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [Y_W-1:0]    y;
  logic [Y_W-SMP_W:0]       y_top;

  // Multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q   <= 1'b0;
      prod_first_q <= 1'b0;
    end else begin
      prod_vld_q   <= ctrl_i.valid;
      prod_first_q <= ctrl_i.first;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= sample_i * coef_at(ctrl_i.idx);
    end
  end

  // Accumulate stage; restart on the first tap
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (prod_vld_q) begin
      acc_d = prod_first_q ? prod_ext : acc_q + prod_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Scale by 2^-15, wrap to 16 bits, flag when the upper bits are not a sign extension
  assign y            = acc_q[ACC_W-1:SHIFT];
  assign y_top        = y[Y_W-1:SMP_W-1];
  assign res_o.filtered = y[SMP_W-1:0];
  assign res_o.overflow = ~((&y_top) | ~(|y_top));
endmodule

[rtl/fir_decimate_by_two.sv]
// Even-phase samples (the first after reset, then every second) yield one result, valid
// after the run, flush and finish states once the output register is free; odd-phase
// samples only shift into the cell row. Requests are accepted only while idle; the single
// shared multiply-accumulate walks the cell row one tap per cycle.
// A finished result waits in the output register while the next sample is accepted.
// Reset (rst_ni low, asynchronous) zeroes the delay cells, the phase and the output valid.
module fir_decimate_by_two (
  input  logic clk_i,
  input  logic rst_ni,
  fdb_smp_if.sink   smp_i,
  fdb_res_if.source res_o
);
  import fdb_pkg::*;

  `include "fir_decimate_by_two_assert.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;
  logic                   phase_q;
  logic                   smp_acc;
  logic                   row_en;
  logic                   out_free;
  logic                   out_load;
  logic                   out_vld_q;
  res_t                   out_q;
  res_t                   mac_res;
  mac_ctrl_t              mac_ctrl;
  logic signed [SMP_W-1:0] cell_d [TAPS];
  logic signed [SMP_W-1:0] cell_q [TAPS];

  assign smp_i.ready = (state_q == ST_IDLE);
  assign smp_acc     = smp_i.valid & smp_i.ready;
  assign row_en      = smp_acc | (state_q == ST_RUN);

  // Cell row: shift toward the oldest slot; the newest slot takes the request or wraps
  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    if (j == TAPS - 1) begin : g_head
      assign cell_d[j] = (state_q == ST_RUN) ? cell_q[0] : smp_i.sample;
    end else begin : g_body
      assign cell_d[j] = cell_q[j+1];
    end
    fdb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (row_en),
      .d_i    (cell_d[j]),
      .q_o    (cell_q[j])
    );
  end

  // Feed the oldest slot to the MAC during the walk
  assign mac_ctrl.valid = (state_q == ST_RUN);
  assign mac_ctrl.first = (cnt_q == '0);
  assign mac_ctrl.idx   = cnt_q;

  fdb_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (cell_q[0]),
    .res_o    (mac_res)
  );

  assign out_free = ~out_vld_q | res_o.ready;
  assign out_load = (state_q == ST_FIN) & out_free;

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (smp_acc && !phase_q) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IDX_W'(TAPS - 1)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: state_d = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (smp_acc) begin
        phase_q <= ~phase_q;
      end
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= mac_res;
    end
  end

  assign res_o.valid    = out_vld_q;
  assign res_o.filtered = out_q.filtered;
  assign res_o.overflow = out_q.overflow;

  `FDB_ASSERT_NOW(a_cnt_range, state_q == ST_RUN, cnt_q <= IDX_W'(TAPS - 1), "tap counter past last tap")
  `FDB_ASSERT_NOW(a_load_from_fin, $rose(out_vld_q), $past(state_q) == ST_FIN, "result loaded outside finish")
  `FDB_ASSERT_NEXT(a_odd_no_run, smp_acc && phase_q, state_q == ST_IDLE, "odd-phase request started a walk")
  `FDB_ASSERT_NEXT(a_even_run, smp_acc && !phase_q, state_q == ST_RUN && cnt_q == '0, "even-phase request did not start a walk")
endmodule

[dv/fdb_check_pkg.sv]
`timescale 1ns / 1ps

package fdb_check_pkg;
  import fdb_pkg::*;

  // Q15 filter weights, oldest sample first
  localparam int WEIGHT_COUNT = 32;
  localparam logic signed [15:0] FIR_WEIGHTS [WEIGHT_COUNT] = '{
    16'sh008d,  16'sh019c,  16'sh01cb, -16'sh0011, -16'sh0254, -16'sh01b4,  16'sh01be,
    16'sh0342, -16'sh002e, -16'sh0426, -16'sh022b,  16'sh03e2,  16'sh04d4, -16'sh0211,
    -16'sh0710, -16'sh0178,  16'sh07c9,  16'sh065e, -16'sh05bb, -16'sh0b75, -16'sh005f,
    16'sh0e25,  16'sh0ae8, -16'sh09a1, -16'sh16fa, -16'sh099a,  16'sh15e9,  16'sh2d66,
    16'sh2d4e,  16'sh1c73,  16'sh0b1e,  16'sh022a
  };
  localparam int Q15_SHIFT = 15;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic signed [15:0] filtered;
    logic               overflow;
  } decim_out_t;

  // Weight of tap j; taps past the table weigh nothing
  function automatic longint tap_weight(int j);
    if (j < WEIGHT_COUNT) begin
      return longint'(FIR_WEIGHTS[j]);
    end
    return 0;
  endfunction

  class decim_scoreboard;
    decim_out_t         pending_outputs[$];
    logic signed [15:0] history [TAPS-1];
    bit                 odd_phase;
    int unsigned        mismatches;

    function new();
      foreach (history[j]) history[j] = '0;
      odd_phase  = 1'b0;
      mismatches = 0;
    endfunction

    // Predict the output for an accepted request, then advance the delay line
    function void note_sample(logic signed [15:0] smp);
      longint     acc;
      longint     y;
      decim_out_t exp_out;
      if (!odd_phase) begin
        acc = 0;
        for (int j = 0; j < TAPS - 1; j++) begin
          acc += tap_weight(j) * longint'(history[j]);
        end
        acc += tap_weight(TAPS - 1) * longint'(smp);
        y = acc >>> Q15_SHIFT;
        exp_out.filtered = y[15:0];
        exp_out.overflow = (y < -32768 || y > 32767);
        pending_outputs.push_back(exp_out);
      end
      for (int j = 0; j < TAPS - 2; j++) begin
        history[j] = history[j + 1];
      end
      history[TAPS-2] = smp;
      odd_phase = ~odd_phase;
    endfunction

    // Compare one output against the oldest prediction
    function void check_output(logic signed [15:0] filtered, logic overflow);
      decim_out_t exp_out;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected output: filtered=%0d overflow=%0b", filtered, overflow);
        end
        return;
      end
      exp_out = pending_outputs.pop_front();
      if (filtered !== exp_out.filtered || overflow !== exp_out.overflow) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("output mismatch: expected filtered=%0d overflow=%0b, got filtered=%0d overflow=%0b",
                   exp_out.filtered, exp_out.overflow, filtered, overflow);
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_outputs.size();
    endfunction

    function int unsigned failures();
      return mismatches + pending_outputs.size();
    endfunction
  endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import fdb_pkg::*;
  import fdb_check_pkg::*;

  localparam int SAMPLE_TARGET = 1950;
  localparam int CHUNK_LEN     = 32;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 80;

  logic clk_i;
  logic rst_ni;
  int unsigned cycle_count;
  int unsigned sent;

  fdb_smp_if smp_if ();
  fdb_res_if res_if ();

  decim_scoreboard board = new();

  fir_decimate_by_two uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .smp_i (smp_if),
    .res_o (res_if)
  );

  // Free-running clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Bound the run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Idle length for one request: none, the full range, or short
  function automatic int idle_cycles(int style);
    case (style)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // Random sample: full range, small, rails, or a single walking bit
  function automatic logic signed [15:0] draw_sample();
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 65535);
      1:       v = int'($urandom_range(0, 255)) - 128;
      2:       v = $urandom_range(0, 1) ? 32767 : -32768;
      default: begin
        v = 1 << $urandom_range(0, 15);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v[15:0];
  endfunction

  // Drive one request after an idle gap and hold it until accepted
  task automatic send_sample(logic signed [15:0] value, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      smp_if.valid = 1'b0;
    end
    @(negedge clk_i);
    smp_if.valid  = 1'b1;
    smp_if.sample = value;
    do begin
      @(posedge clk_i);
    end while (smp_if.ready !== 1'b1);
    board.note_sample(value);
    sent++;
  endtask

  // Sign-matched burst that drives the sum toward the rails
  task automatic send_aligned_burst(int style);
    int amp;
    int v;
    bit flip;
    amp  = $urandom_range(16000, 32767);
    flip = $urandom_range(0, 1);
    for (int j = 0; j < WEIGHT_COUNT; j++) begin
      v = ((FIR_WEIGHTS[j] < 0) ^ flip) ? -amp : amp;
      if (flip && v > 0 && $urandom_range(0, 3) == 0) v = -32768;
      send_sample(v[15:0], idle_cycles(style));
    end
  endtask

  // Accept outputs with random stalls and check each one
  initial begin : drain_outputs
    int gap;
    int style;
    int unsigned got;
    got          = 0;
    style        = 0;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (got % CHUNK_LEN == 0) style = $urandom_range(0, 2);
      gap = idle_cycles(style);
      repeat (gap) begin
        @(negedge clk_i);
        res_if.ready = 1'b0;
      end
      @(negedge clk_i);
      res_if.ready = 1'b1;
      do begin
        @(posedge clk_i);
      end while (res_if.valid !== 1'b1);
      board.check_output(res_if.filtered, res_if.overflow);
      got++;
    end
  end

  // Reset, directed requests, random chunks, then drain
  initial begin : stimulus
    int style;
    logic signed [15:0] directed [$];
    sent          = 0;
    rst_ni        = 1'b0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Rails, zero, unit steps and alternating bit patterns on both phases
    directed = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001,
                 16'sh5555, -16'sh5556, 16'sh7fff, 16'sh7fff, -16'sh8000,
                 -16'sh8000, 16'sh0000, 16'sh7fff, -16'sh8000, 16'sh4000,
                 -16'sh4000};
    foreach (directed[k]) send_sample(directed[k], 0);

    // Random chunks, many of them pushing the output past the rails
    while (sent < SAMPLE_TARGET) begin
      style = $urandom_range(0, 2);
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 1)) send_sample(draw_sample(), idle_cycles(style));
        send_aligned_burst(style);
      end else begin
        repeat (CHUNK_LEN) send_sample(draw_sample(), idle_cycles(style));
      end
    end

    @(negedge clk_i);
    smp_if.valid = 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.failures() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
